@@ rtl/assert_macros.svh @@
// Assertion macros used by the interpolator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define PLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, also during reset.
`define PLI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/pli_pkg.sv @@
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CW    = 6;
  localparam int unsigned CNT_W     = 5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [1:0] {
    OUT_ZERO   = 2'd0,
    OUT_ERR    = 2'd1,
    OUT_INTERP = 2'd2
  } out_kind_e;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RDLAST  = 7'b0000010,
    S_CHKLAST = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_MUL     = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic      capture;
    logic      wr_en;
    logic      rd_en;
    logic      save_prev;
    logic      mul_start;
    logic      div_step;
    logic      out_load;
    out_kind_e out_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic above_rd;
    logic below_rd;
    logic seg_hit;
  } dp_status_t;

endpackage

@@ rtl/pli_dpath.sv @@
// Datapath: breakpoint memory, segment compares, multiplier, divider, output register.
module pli_dpath #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned IW         = 4
) (
  input  logic                clk_i,
  input  pli_pkg::ctl_cmd_t   cmd_i,
  input  logic [IW-1:0]       rd_addr_i,
  input  logic [3:0]          point_index_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  query_x_i,
  output pli_pkg::dp_status_t status_o,
  output logic signed [31:0]  result_y_o,
  output logic                err_o
);
  import pli_pkg::*;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];

  logic signed [31:0] q_q, rd_x_q, rd_y_q, prev_x_q, prev_y_q, y0_q;
  logic        [63:0] dvd_q;
  logic        [31:0] rem_q, dx_q;
  logic               dxz_q, neg_q;
  logic signed [31:0] res_q;
  logic               err_q;

  logic               idx_ok;
  logic signed [32:0] dx, tt, dy, dy_mag;
  logic        [32:0] shifted, diff;
  logic               fits;
  logic signed [31:0] step, interp;

  assign idx_ok = 32'(point_index_i) < MAX_POINTS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && idx_ok) begin
      mem_x[IW'(point_index_i)] <= point_x_i;
      mem_y[IW'(point_index_i)] <= point_y_i;
    end
    if (cmd_i.rd_en) begin
      rd_x_q <= mem_x[rd_addr_i];
      rd_y_q <= mem_y[rd_addr_i];
    end
  end

  assign status_o.above_rd = q_q > rd_x_q;
  assign status_o.below_rd = q_q < rd_x_q;
  assign status_o.seg_hit  = (prev_x_q <= q_q) && (q_q <= rd_x_q);

  always_comb begin
    dx      = 33'(rd_x_q) - 33'(prev_x_q);
    tt      = 33'(q_q) - 33'(prev_x_q);
    dy      = 33'(rd_y_q) - 33'(prev_y_q);
    dy_mag  = dy[32] ? -dy : dy;
    shifted = {rem_q, dvd_q[63]};
    diff    = shifted - {1'b0, dx_q};
    fits    = shifted >= {1'b0, dx_q};
    step    = neg_q ? -$signed(dvd_q[31:0]) : $signed(dvd_q[31:0]);
    interp  = dxz_q ? y0_q : y0_q + step;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) q_q <= query_x_i;
    if (cmd_i.save_prev) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    if (cmd_i.mul_start) begin
      dvd_q <= 64'(tt[31:0]) * 64'(dy_mag[31:0]);
      rem_q <= '0;
      dx_q  <= dx[31:0];
      dxz_q <= dx == '0;
      neg_q <= dy[32];
      y0_q  <= prev_y_q;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[31:0] : shifted[31:0];
      dvd_q <= {dvd_q[62:0], fits};
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        OUT_INTERP: begin
          res_q <= interp;
          err_q <= 1'b0;
        end
        OUT_ERR: begin
          res_q <= '0;
          err_q <= 1'b1;
        end
        default: begin
          res_q <= '0;
          err_q <= 1'b0;
        end
      endcase
    end
  end

  assign result_y_o = res_q;
  assign err_o      = err_q;

endmodule

@@ rtl/pli_ctrl.sv @@
// Controller: sequencing of load, range check, segment scan, multiply and divide.
`include "assert_macros.svh"
module pli_ctrl #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned IW         = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pli_pkg::dp_status_t status_i,
  output pli_pkg::ctl_cmd_t   cmd_o,
  output logic [IW-1:0]       rd_addr_o
);
  import pli_pkg::*;

  localparam int unsigned CW = ($clog2(MAX_POINTS + 1) > CNT_W) ?
                               $clog2(MAX_POINTS + 1) : CNT_W;

  state_e          state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [IW-1:0]   k_q, k_d;
  logic [DIV_CW-1:0] dcnt_q, dcnt_d;
  out_kind_e       kind_q, kind_d;
  logic            out_valid_q, out_valid_d;
  logic [CW-1:0]   n_clamp;
  logic [IW-1:0]   last_idx;
  logic            accept, slot_free;

  always_comb begin
    n_clamp = CW'(count_q);
    if (n_clamp < CW'(2)) n_clamp = CW'(2);
    if (n_clamp > CW'(MAX_POINTS)) n_clamp = CW'(MAX_POINTS);
  end
  assign last_idx = IW'(n_clamp - CW'(1));

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    dcnt_d    = dcnt_q;
    kind_d    = kind_q;
    cmd_o     = '0;
    cmd_o.out_kind = kind_q;
    rd_addr_o = k_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_LOAD) begin
            cmd_o.wr_en = 1'b1;
            kind_d      = OUT_ZERO;
            state_d     = S_DONE;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = S_RDLAST;
          end
        end
      end
      S_RDLAST: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = last_idx;
        state_d     = S_CHKLAST;
      end
      S_CHKLAST: begin
        if (status_i.above_rd) begin
          kind_d  = OUT_ERR;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = '0;
          k_d         = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_q == '0 && status_i.below_rd) begin
          kind_d  = OUT_ERR;
          state_d = S_DONE;
        end else if (k_q != '0 && status_i.seg_hit) begin
          state_d = S_MUL;
        end else if (k_q == last_idx) begin
          kind_d  = OUT_ERR;
          state_d = S_DONE;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.rd_en     = 1'b1;
          rd_addr_o       = k_q + IW'(1);
          k_d             = k_q + IW'(1);
        end
      end
      S_MUL: begin
        cmd_o.mul_start = 1'b1;
        dcnt_d          = '0;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + DIV_CW'(1);
        if (dcnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          kind_d  = OUT_INTERP;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(2);
      k_q         <= '0;
      dcnt_q      <= '0;
      kind_q      <= OUT_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      dcnt_q      <= dcnt_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o = out_valid_q;

  `PLI_ASSERT(a_rd_in_table, cmd_o.rd_en |-> rd_addr_o <= last_idx, "read beyond active table")
  `PLI_ASSERT(a_div_full, (state_q == S_DONE && $past(state_q == S_DIV)) |-> $past(dcnt_q == DIV_CW'(DIV_STEPS - 1)), "divide left early")
  `PLI_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without completion")

endmodule

@@ rtl/piecewise_linear_interpolator.sv @@
// Top level of the piecewise linear interpolator with its breakpoint table.
// A load request writes one point; an evaluate request reads the last and first points,
// scans one breakpoint a cycle, then does a multiply and a bit-serial divide.
// Throughput: one request at a time; the next is accepted after the result is registered.
// Async active-low reset clears control state and sets point_count to 2; table is unset.
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] point_index, [35:4] point_x, [67:36] point_y, [99:68] query_x, rest zero
  input  logic [103:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result_y
  output logic [31:0]  m_axis_tdata,
  // [0] status
  output logic         m_axis_tuser
);
  import pli_pkg::*;

  // Address width of the breakpoint memory.
  localparam int unsigned IW = $clog2(MAX_POINTS);

  ctl_cmd_t         cmd;
  dp_status_t       status;
  logic [IW-1:0]    rd_addr;
  logic signed [31:0] result_y;
  logic             err;

  // The controller sequences every request; the datapath holds the table
  // and the arithmetic and reports only compare results back.
  pli_ctrl #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  pli_dpath #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .point_index_i (s_axis_tdata[3:0]),
    .point_x_i     (s_axis_tdata[35:4]),
    .point_y_i     (s_axis_tdata[67:36]),
    .query_x_i     (s_axis_tdata[99:68]),
    .status_o      (status),
    .result_y_o    (result_y),
    .err_o         (err)
  );

  assign m_axis_tdata = result_y;
  assign m_axis_tuser = err;

endmodule
